// ===== design/pet_pkg.sv =====
// shared types and codes for the pointer event translator
package pet_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned CMD_W       = 3;
    localparam int unsigned COORD_W     = 32;
    localparam int unsigned BTN_W       = 8;
    localparam int unsigned TIME_W      = 48;
    localparam int unsigned S_DATA_W    = 192;
    localparam int unsigned M_DATA_W    = 192;

    localparam logic [CMD_W-1:0] CMD_MOVE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_BUTTON = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WHEEL  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FOCUS  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LEAVE  = 3'd4;

    typedef enum logic [2:0] {
        PH_ADD    = 3'd0,
        PH_REMOVE = 3'd1,
        PH_HOVER  = 3'd2,
        PH_DOWN   = 3'd3,
        PH_MOVE   = 3'd4,
        PH_UP     = 3'd5,
        PH_CANCEL = 3'd6
    } phase_t;

    localparam logic KIND_POINTER = 1'b0;
    localparam logic KIND_FOCUS   = 1'b1;

    // results still owed for one input, emitted in field order from the top
    typedef struct packed {
        logic add;
        logic ptr;
        logic cancel;
        logic remove;
        logic focus;
    } act_t;

    typedef struct packed {
        act_t                act;
        phase_t              ptr_phase;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [BTN_W-1:0]    buttons;
        logic                wheel;
        logic [COORD_W-1:0]  dx;
        logic [COORD_W-1:0]  dy;
        logic [TIME_W-1:0]   time_us;
        logic                focus;
    } desc_t;

endpackage

// ===== design/pet_front.sv =====
// front end: accepts raw events, tracks pointer and focus state, plans results
module pet_front
    import pet_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CMD_W-1:0]   in_cmd,
    input  logic [COORD_W-1:0] in_x,
    input  logic [COORD_W-1:0] in_y,
    input  logic [BTN_W-1:0]   in_btn,
    input  logic               in_focus,
    input  logic [COORD_W-1:0] in_dx,
    input  logic [COORD_W-1:0] in_dy,
    input  logic [TIME_W-1:0]  in_time,
    output logic               push_valid,
    input  logic               push_ready,
    output desc_t              push_data
);

    logic               added_reg, added_next;
    logic               down_reg, down_next;
    logic [BTN_W-1:0]   held_reg, held_next;
    logic [COORD_W-1:0] last_x_reg, last_x_next;
    logic [COORD_W-1:0] last_y_reg, last_y_next;
    logic               fvalid_reg, fvalid_next;
    logic               fheld_reg, fheld_next;
    logic               accept;
    logic               do_drop;
    logic               do_ptr;
    desc_t              d;

    assign in_ready   = push_ready;
    assign accept     = in_valid && push_ready;
    assign push_valid = accept && (|d.act);
    assign push_data  = d;

    always_comb begin
        added_next  = added_reg;
        down_next   = down_reg;
        held_next   = held_reg;
        last_x_next = last_x_reg;
        last_y_next = last_y_reg;
        fvalid_next = fvalid_reg;
        fheld_next  = fheld_reg;
        do_drop     = 1'b0;
        do_ptr      = 1'b0;
        d           = '0;
        d.time_us   = in_time;
        d.focus     = in_focus;
        d.x         = last_x_reg;
        d.y         = last_y_reg;
        d.buttons   = held_reg;
        d.ptr_phase = PH_HOVER;

        unique case (in_cmd)
            CMD_FOCUS: begin
                do_drop = !in_focus;
                if (!fvalid_reg || (fheld_reg != in_focus)) begin
                    d.act.focus = 1'b1;
                    fvalid_next = 1'b1;
                    fheld_next  = in_focus;
                end
            end
            CMD_LEAVE: begin
                do_drop = 1'b1;
            end
            default: begin
                if ((in_cmd == CMD_BUTTON) && !added_reg && (in_btn == '0)) begin
                    down_next = 1'b0;
                    held_next = '0;
                end else if (!((in_cmd == CMD_BUTTON) && (in_btn == held_reg))) begin
                    do_ptr = 1'b1;
                end
            end
        endcase

        if (do_drop) begin
            d.act.cancel = added_reg && down_reg;
            d.act.remove = added_reg;
            added_next   = 1'b0;
            down_next    = 1'b0;
            held_next    = '0;
        end

        if (do_ptr) begin
            last_x_next = in_x;
            last_y_next = in_y;
            held_next   = in_btn;
            added_next  = 1'b1;
            d.act.add   = !added_reg;
            d.act.ptr   = 1'b1;
            d.x         = in_x;
            d.y         = in_y;
            d.buttons   = in_btn;
            d.wheel     = (in_cmd == CMD_WHEEL);
            d.dx        = (in_cmd == CMD_WHEEL) ? in_dx : '0;
            d.dy        = (in_cmd == CMD_WHEEL) ? in_dy : '0;
            if (in_btn == '0) begin
                d.ptr_phase = down_reg ? PH_UP : PH_HOVER;
                down_next   = 1'b0;
            end else begin
                d.ptr_phase = down_reg ? PH_MOVE : PH_DOWN;
                down_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            added_reg  <= 1'b0;
            down_reg   <= 1'b0;
            held_reg   <= '0;
            last_x_reg <= '0;
            last_y_reg <= '0;
            fvalid_reg <= 1'b0;
            fheld_reg  <= 1'b0;
        end else if (accept) begin
            added_reg  <= added_next;
            down_reg   <= down_next;
            held_reg   <= held_next;
            last_x_reg <= last_x_next;
            last_y_reg <= last_y_next;
            fvalid_reg <= fvalid_next;
            fheld_reg  <= fheld_next;
        end
    end

endmodule

// ===== design/pet_queue.sv =====
// short register queue of planned result groups between front and back
module pet_queue
    import pet_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    output logic  push_ready,
    input  desc_t push_data,
    output logic  pop_valid,
    input  logic  pop_ready,
    output desc_t pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    desc_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (cnt_reg != FULL_CNT);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_next  = do_push ? ((wr_reg == LAST_IDX) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = do_pop ? ((rd_reg == LAST_IDX) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== design/pet_back.sv =====
// back end: expands each planned group into result beats, one per cycle while the output is free
module pet_back
    import pet_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  desc_t              pop_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_kind,
    output logic               out_last,
    output phase_t             out_phase,
    output logic [COORD_W-1:0] out_x,
    output logic [COORD_W-1:0] out_y,
    output logic [BTN_W-1:0]   out_buttons,
    output logic               out_scroll,
    output logic [COORD_W-1:0] out_dx,
    output logic [COORD_W-1:0] out_dy,
    output logic [TIME_W-1:0]  out_time,
    output logic               out_focus
);

    logic               work_valid_reg, work_valid_next;
    desc_t              work_reg, work_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_kind_reg, m_kind_next;
    logic               m_last_reg, m_last_next;
    phase_t             m_phase_reg, m_phase_next;
    logic [COORD_W-1:0] m_x_reg, m_x_next;
    logic [COORD_W-1:0] m_y_reg, m_y_next;
    logic [BTN_W-1:0]   m_btn_reg, m_btn_next;
    logic               m_scroll_reg, m_scroll_next;
    logic [COORD_W-1:0] m_dx_reg, m_dx_next;
    logic [COORD_W-1:0] m_dy_reg, m_dy_next;
    logic [TIME_W-1:0]  m_time_reg, m_time_next;
    logic               m_focus_reg, m_focus_next;
    logic               out_free;
    logic               emit;
    act_t               remain;
    logic               done;

    assign out_free  = !m_valid_reg || out_ready;
    assign emit      = work_valid_reg && out_free;
    assign pop_ready = !work_valid_reg || (emit && done);

    always_comb begin
        remain          = work_reg.act;
        m_valid_next    = m_valid_reg && !out_ready;
        m_kind_next     = m_kind_reg;
        m_phase_next    = m_phase_reg;
        m_x_next        = m_x_reg;
        m_y_next        = m_y_reg;
        m_btn_next      = m_btn_reg;
        m_scroll_next   = m_scroll_reg;
        m_dx_next       = m_dx_reg;
        m_dy_next       = m_dy_reg;
        m_time_next     = m_time_reg;
        m_focus_next    = m_focus_reg;
        work_valid_next = work_valid_reg;
        work_next       = work_reg;

        // pick the highest pending result in emission order
        if (work_reg.act.add) begin
            remain.add = 1'b0;
        end else if (work_reg.act.ptr) begin
            remain.ptr = 1'b0;
        end else if (work_reg.act.cancel) begin
            remain.cancel = 1'b0;
        end else if (work_reg.act.remove) begin
            remain.remove = 1'b0;
        end else begin
            remain.focus = 1'b0;
        end
        done        = (remain == '0);
        m_last_next = emit ? done : m_last_reg;

        if (emit) begin
            m_valid_next  = 1'b1;
            m_kind_next   = KIND_POINTER;
            m_x_next      = work_reg.x;
            m_y_next      = work_reg.y;
            m_btn_next    = '0;
            m_scroll_next = 1'b0;
            m_dx_next     = '0;
            m_dy_next     = '0;
            m_time_next   = work_reg.time_us;
            m_focus_next  = 1'b0;
            if (work_reg.act.add) begin
                m_phase_next = PH_ADD;
            end else if (work_reg.act.ptr) begin
                m_phase_next  = work_reg.ptr_phase;
                m_btn_next    = work_reg.buttons;
                m_scroll_next = work_reg.wheel;
                m_dx_next     = work_reg.dx;
                m_dy_next     = work_reg.dy;
            end else if (work_reg.act.cancel) begin
                m_phase_next = PH_CANCEL;
                m_btn_next   = work_reg.buttons;
            end else if (work_reg.act.remove) begin
                m_phase_next = PH_REMOVE;
            end else begin
                m_kind_next  = KIND_FOCUS;
                m_phase_next = PH_ADD;
                m_x_next     = '0;
                m_y_next     = '0;
                m_focus_next = work_reg.focus;
            end
            work_next.act = remain;
        end

        if (pop_ready) begin
            work_valid_next = pop_valid;
            work_next       = pop_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            work_valid_reg <= work_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        work_reg     <= work_next;
        m_kind_reg   <= m_kind_next;
        m_last_reg   <= m_last_next;
        m_phase_reg  <= m_phase_next;
        m_x_reg      <= m_x_next;
        m_y_reg      <= m_y_next;
        m_btn_reg    <= m_btn_next;
        m_scroll_reg <= m_scroll_next;
        m_dx_reg     <= m_dx_next;
        m_dy_reg     <= m_dy_next;
        m_time_reg   <= m_time_next;
        m_focus_reg  <= m_focus_next;
    end

    assign out_valid   = m_valid_reg;
    assign out_kind    = m_kind_reg;
    assign out_last    = m_last_reg;
    assign out_phase   = m_phase_reg;
    assign out_x       = m_x_reg;
    assign out_y       = m_y_reg;
    assign out_buttons = m_btn_reg;
    assign out_scroll  = m_scroll_reg;
    assign out_dx      = m_dx_reg;
    assign out_dy      = m_dy_reg;
    assign out_time    = m_time_reg;
    assign out_focus   = m_focus_reg;

endmodule

// ===== design/pointer_event_translator.sv =====
// top level of the pointer event translator
//
// Input beats on the s_ channel carry one raw mouse event each (move, button,
// wheel, focus, leave; the kind travels in s_tuser). Result beats on the m_
// channel are pointer lifecycle events or focus change events, m_tuser tells
// which, and m_tlast marks the last result caused by one input.
// An input causes zero to three results. The front end updates the pointer
// and focus state in the cycle an event is accepted and queues a plan of the
// results it owes; the back end turns each plan into beats in an output register,
// one per cycle while the receiver takes them or the register is empty.
// An accepted event passes through the queue, the back end's work register and
// the output register before its first result is valid. The input takes one
// event per cycle while the queue has room; events that cause no result are
// not queued.
// After reset there is no pointer, no buttons are held, focus is unknown and
// the queue is empty. When the receiver stalls, the output beat holds, the
// back end waits, and once the queue fills s_tready drops.
module pointer_event_translator
    import pet_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // pos_x, pos_y, button_mask, focus_in, scroll_dx, scroll_dy, time_us, zero fill
    input  logic [S_DATA_W-1:0] s_tdata,
    // command
    input  logic [CMD_W-1:0]    s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // phase, out_x, out_y, out_buttons, is_scroll, out_scroll_dx, out_scroll_dy,
    // out_time_us, focus_out, zero fill
    output logic [M_DATA_W-1:0] m_tdata,
    // result_kind
    output logic                m_tuser,
    output logic                m_tlast
);

    logic               push_valid;
    logic               push_ready;
    desc_t              push_data;
    logic               pop_valid;
    logic               pop_ready;
    desc_t              pop_data;
    phase_t             o_phase;
    logic [COORD_W-1:0] o_x;
    logic [COORD_W-1:0] o_y;
    logic [BTN_W-1:0]   o_btn;
    logic               o_scroll;
    logic [COORD_W-1:0] o_dx;
    logic [COORD_W-1:0] o_dy;
    logic [TIME_W-1:0]  o_time;
    logic               o_focus;

    pet_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tuser),
        .in_x       (s_tdata[31:0]),
        .in_y       (s_tdata[63:32]),
        .in_btn     (s_tdata[71:64]),
        .in_focus   (s_tdata[72]),
        .in_dx      (s_tdata[104:73]),
        .in_dy      (s_tdata[136:105]),
        .in_time    (s_tdata[184:137]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    pet_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    pet_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (m_tuser),
        .out_last    (m_tlast),
        .out_phase   (o_phase),
        .out_x       (o_x),
        .out_y       (o_y),
        .out_buttons (o_btn),
        .out_scroll  (o_scroll),
        .out_dx      (o_dx),
        .out_dy      (o_dy),
        .out_time    (o_time),
        .out_focus   (o_focus)
    );

    assign m_tdata = {3'b000, o_focus, o_time, o_dy, o_dx, o_scroll, o_btn, o_y, o_x, o_phase};

endmodule

// ===== bench/pet_checker.sv =====
// checker for the pointer event translator: predicts result beats and compares them
`timescale 1ns / 1ps

module pet_checker
    import pet_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [CMD_W-1:0]    s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic                m_tuser,
    input  logic                m_tlast,
    output int                  mismatches,
    output int                  owed,
    output int                  events_taken,
    output int                  beats_checked
);

    typedef struct packed {
        logic               kind;
        phase_t             phase;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [BTN_W-1:0]   buttons;
        logic               scroll;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        logic [TIME_W-1:0]  stamp;
        logic               focus;
        logic               last;
    } event_beat_t;

    event_beat_t pending_beats[$];
    event_beat_t run_buf[3];
    int          run_len;

    logic               ptr_live;
    logic               ptr_pressed;
    logic [BTN_W-1:0]   btn_held;
    logic [COORD_W-1:0] pos_x_held;
    logic [COORD_W-1:0] pos_y_held;
    logic               focus_seen;
    logic               focus_state;

    int err_count   = 0;
    int event_count = 0;
    int beat_count  = 0;

    initial begin
        mismatches    = 0;
        owed          = 0;
        events_taken  = 0;
        beats_checked = 0;
    end

    function automatic void add_beat(input logic kind, input phase_t ph,
                                     input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                     input logic [BTN_W-1:0] btn, input logic scroll,
                                     input logic [COORD_W-1:0] dx, input logic [COORD_W-1:0] dy,
                                     input logic [TIME_W-1:0] stamp, input logic foc);
        event_beat_t b;
        b.kind    = kind;
        b.phase   = ph;
        b.x       = x;
        b.y       = y;
        b.buttons = btn;
        b.scroll  = scroll;
        b.dx      = dx;
        b.dy      = dy;
        b.stamp   = stamp;
        b.focus   = foc;
        b.last    = 1'b0;
        run_buf[run_len] = b;
        run_len++;
    endfunction

    // cancel a pressed pointer, then remove it at the held position
    function automatic void drop_pointer(input logic [TIME_W-1:0] stamp);
        if (ptr_live) begin
            if (ptr_pressed)
                add_beat(KIND_POINTER, PH_CANCEL, pos_x_held, pos_y_held, btn_held, 1'b0,
                         '0, '0, stamp, 1'b0);
            add_beat(KIND_POINTER, PH_REMOVE, pos_x_held, pos_y_held, '0, 1'b0,
                     '0, '0, stamp, 1'b0);
        end
        ptr_live    = 1'b0;
        ptr_pressed = 1'b0;
        btn_held    = '0;
    endfunction

    function automatic void translate_event(input logic [CMD_W-1:0] cmd,
                                            input logic [S_DATA_W-1:0] d);
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [BTN_W-1:0]   btn;
        logic               foc;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        logic [TIME_W-1:0]  stamp;
        logic               wheel;
        phase_t             ph;
        event_beat_t        b;
        x     = d[31:0];
        y     = d[63:32];
        btn   = d[71:64];
        foc   = d[72];
        dx    = d[104:73];
        dy    = d[136:105];
        stamp = d[184:137];
        wheel = (cmd == CMD_WHEEL);
        run_len = 0;
        if (cmd == CMD_FOCUS) begin
            if (!foc)
                drop_pointer(stamp);
            if (!focus_seen || focus_state != foc) begin
                // focus beats carry a zero phase
                add_beat(KIND_FOCUS, PH_ADD, '0, '0, '0, 1'b0, '0, '0, stamp, foc);
                focus_seen  = 1'b1;
                focus_state = foc;
            end
        end else if (cmd == CMD_LEAVE) begin
            drop_pointer(stamp);
        end else if (cmd == CMD_BUTTON && !ptr_live && btn == '0) begin
            ptr_pressed = 1'b0;
            btn_held    = '0;
        end else if (!(cmd == CMD_BUTTON && btn == btn_held)) begin
            pos_x_held = x;
            pos_y_held = y;
            btn_held   = btn;
            if (!ptr_live) begin
                add_beat(KIND_POINTER, PH_ADD, x, y, '0, 1'b0, '0, '0, stamp, 1'b0);
                ptr_live = 1'b1;
            end
            if (btn == '0)
                ph = ptr_pressed ? PH_UP : PH_HOVER;
            else
                ph = ptr_pressed ? PH_MOVE : PH_DOWN;
            add_beat(KIND_POINTER, ph, x, y, btn, wheel, wheel ? dx : '0, wheel ? dy : '0,
                     stamp, 1'b0);
            if (ph == PH_DOWN)
                ptr_pressed = 1'b1;
            else if (ph == PH_UP)
                ptr_pressed = 1'b0;
        end
        for (int i = 0; i < run_len; i++) begin
            b      = run_buf[i];
            b.last = (i == run_len - 1);
            pending_beats.push_back(b);
        end
    endfunction

    function automatic string show_beat(input event_beat_t b);
        return $sformatf({"kind %0d phase %0d x %h y %h btn %h scroll %0d dx %h dy %h ",
                          "t %h focus %0d last %0d"},
                         b.kind, b.phase, b.x, b.y, b.buttons, b.scroll, b.dx, b.dy,
                         b.stamp, b.focus, b.last);
    endfunction

    always @(posedge aclk) begin
        event_beat_t got;
        event_beat_t want;
        if (!aresetn) begin
            ptr_live    = 1'b0;
            ptr_pressed = 1'b0;
            btn_held    = '0;
            pos_x_held  = '0;
            pos_y_held  = '0;
            focus_seen  = 1'b0;
            focus_state = 1'b0;
            pending_beats.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                translate_event(s_tuser, s_tdata);
                event_count++;
            end
            if (m_tvalid && m_tready) begin
                got.kind    = m_tuser;
                got.phase   = phase_t'(m_tdata[2:0]);
                got.x       = m_tdata[34:3];
                got.y       = m_tdata[66:35];
                got.buttons = m_tdata[74:67];
                got.scroll  = m_tdata[75];
                got.dx      = m_tdata[107:76];
                got.dy      = m_tdata[139:108];
                got.stamp   = m_tdata[187:140];
                got.focus   = m_tdata[188];
                got.last    = m_tlast;
                beat_count++;
                if (pending_beats.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected result beat: %s", show_beat(got));
                end else begin
                    want = pending_beats.pop_front();
                    if (got !== want) begin
                        err_count++;
                        if (err_count <= 10) begin
                            $display("result beat mismatch at %0t", $realtime);
                            $display("  expected %s", show_beat(want));
                            $display("  actual   %s", show_beat(got));
                        end
                    end
                end
            end
        end
        mismatches    <= err_count;
        owed          <= pending_beats.size();
        events_taken  <= event_count;
        beats_checked <= beat_count;
    end

endmodule

// ===== bench/pointer_event_translator_tb.sv =====
// testbench top for the pointer event translator: stimulus, idling phases and verdict
`timescale 1ns / 1ps

module pointer_event_translator_tb;
    import pet_pkg::*;

    localparam int RANDOM_EVENTS = 70;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 16;

    localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [CMD_W-1:0]    s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    int mismatches;
    int owed;
    int events_taken;
    int beats_checked;

    int gap_pct   = 0;
    int stall_pct = 0;
    int cycles    = 0;
    logic [BTN_W-1:0] mask_guess = '0;

    always #5 aclk = ~aclk;

    pointer_event_translator DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    pet_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .mismatches    (mismatches),
        .owed          (owed),
        .events_taken  (events_taken),
        .beats_checked (beats_checked)
    );

    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_event(input logic [CMD_W-1:0] cmd,
                              input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic [BTN_W-1:0] mask, input logic foc,
                              input logic [COORD_W-1:0] dx, input logic [COORD_W-1:0] dy,
                              input logic [TIME_W-1:0] stamp);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'b0, stamp, dy, dx, foc, mask, y, x};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(15))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_stamp();
        return {16'($urandom_range(65535)), 32'($urandom)};
    endfunction

    initial begin
        logic [CMD_W-1:0] cmd;
        logic [BTN_W-1:0] mask;
        logic             foc;
        int               pick;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: no pointer yet, focus unknown
        send_event(CMD_BUTTON, 32'h10, 32'h20, 8'h00, 1'b1, '0, '0, 48'h0);
        send_event(CMD_LEAVE, 32'h10, 32'h20, 8'h00, 1'b0, '0, '0, 48'h1);
        send_event(CMD_FOCUS, '0, '0, 8'h00, 1'b0, '0, '0, 48'h2);
        send_event(CMD_FOCUS, '0, '0, 8'h00, 1'b0, '0, '0, 48'h3);
        // add, press, repeated press, drag with wheel, drag, release, press again
        send_event(CMD_MOVE, 32'h8000_0000, 32'h7fff_ffff, 8'h00, 1'b0, '0, '0, 48'h0);
        send_event(CMD_BUTTON, 32'h7fff_ffff, 32'h8000_0000, 8'hff, 1'b0, '0, '0,
                   48'hffff_ffff_ffff);
        send_event(CMD_BUTTON, 32'h1, 32'h1, 8'hff, 1'b0, '0, '0, 48'h5);
        send_event(CMD_WHEEL, 32'hffff_ffff, 32'h0, 8'hff, 1'b1, 32'h7fff_ffff,
                   32'h8000_0000, 48'h6);
        send_event(CMD_MOVE, 32'h100, 32'h200, 8'h01, 1'b0, '0, '0, 48'h7);
        send_event(CMD_BUTTON, 32'h100, 32'h200, 8'h00, 1'b0, '0, '0, 48'h8);
        send_event(CMD_BUTTON, 32'h180, 32'h280, 8'h80, 1'b0, '0, '0, 48'h9);
        // focus gained, repeated, then lost with the pointer pressed
        send_event(CMD_FOCUS, '0, '0, 8'h00, 1'b1, '0, '0, 48'ha);
        send_event(CMD_FOCUS, '0, '0, 8'h00, 1'b1, '0, '0, 48'hb);
        send_event(CMD_FOCUS, 32'h55, 32'h66, 8'h00, 1'b0, '0, '0, 48'hc);
        // wheel re-adds the pointer, leave removes it while hovering
        send_event(CMD_WHEEL, 32'h300, 32'h400, 8'h00, 1'b0, 32'hffff_ffff, 32'h0, 48'hd);
        send_event(CMD_LEAVE, 32'h0, 32'h0, 8'h00, 1'b0, '0, '0, 48'he);
        // unused command codes act as moves
        send_event(CMD_RSVD5, 32'h500, 32'h600, 8'h04, 1'b0, '0, '0, 48'hf);
        send_event(CMD_RSVD6, 32'h510, 32'h610, 8'h04, 1'b0, '0, '0, 48'h10);
        send_event(CMD_RSVD7, 32'h520, 32'h620, 8'h00, 1'b0, '0, '0, 48'h11);
        // leave while pressed
        send_event(CMD_BUTTON, 32'h530, 32'h630, 8'h02, 1'b0, '0, '0, 48'h12);
        send_event(CMD_LEAVE, 32'h0, 32'h0, 8'h00, 1'b0, '0, '0, 48'h13);
        // focus lost with a hovering pointer
        send_event(CMD_FOCUS, '0, '0, 8'h00, 1'b1, '0, '0, 48'h14);
        send_event(CMD_MOVE, 32'h540, 32'h640, 8'h00, 1'b0, '0, '0, 48'h15);
        send_event(CMD_FOCUS, '0, '0, 8'h00, 1'b0, '0, '0, 48'h16);

        for (int i = 0; i < RANDOM_EVENTS; i++) begin
            case ((i * 4) / RANDOM_EVENTS)
                0: begin gap_pct = 0;  stall_pct <= 0;  end
                1: begin gap_pct = 55; stall_pct <= 0;  end
                2: begin gap_pct = 0;  stall_pct <= 55; end
                default: begin gap_pct = 35; stall_pct <= 35; end
            endcase
            // occasional unchanged button beat, dropped by the block
            if ($urandom_range(9) == 0)
                send_event(CMD_BUTTON, pick_coord(), pick_coord(), mask_guess,
                           1'($urandom), $urandom, $urandom, pick_stamp());
            pick = $urandom_range(99);
            foc  = 1'($urandom);
            if ($urandom_range(9) < 7)
                mask = mask_guess;
            else
                mask = 8'($urandom_range(255));
            if (pick < 30)
                cmd = CMD_MOVE;
            else if (pick < 55)
                cmd = CMD_BUTTON;
            else if (pick < 70)
                cmd = CMD_WHEEL;
            else if (pick < 80)
                cmd = CMD_FOCUS;
            else if (pick < 90)
                cmd = CMD_LEAVE;
            else
                cmd = 3'($urandom_range(CMD_RSVD5, CMD_RSVD7));
            if (cmd == CMD_BUTTON) begin
                case ($urandom_range(3))
                    0:       mask = '0;
                    1:       mask = 8'h01 << $urandom_range(7);
                    2:       mask = mask_guess | (8'h01 << $urandom_range(7));
                    default: mask = 8'($urandom_range(255));
                endcase
            end
            send_event(cmd, pick_coord(), pick_coord(), mask, foc, pick_coord(), pick_coord(),
                       pick_stamp());
            if (cmd == CMD_LEAVE || (cmd == CMD_FOCUS && !foc))
                mask_guess = '0;
            else if (cmd != CMD_FOCUS)
                mask_guess = mask;
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (owed != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d input events and %0d result beats checked", events_taken, beats_checked);
        $display("directed cases, then random traffic with no idling, sender gaps, stalls, both");
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
design/pet_pkg.sv
design/pet_front.sv
design/pet_queue.sv
design/pet_back.sv
design/pointer_event_translator.sv
bench/pet_checker.sv
bench/pointer_event_translator_tb.sv
